[rtl/svpm_pkg.sv]
// svpm_pkg: shared types, constants and the quarter-wave sine table of the
// space vector modulator. Depends on nothing; all rtl/svpm_* files use it.
package svpm_pkg;

   // angle resolution kept from the 16-bit command and quarter-wave depth
   localparam int ANGLE_BITS       = 16;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int IN_ANGLE_W = 16;
   localparam int FRAC_BITS  = ANGLE_BITS - 2;
   localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_W     = FRAC_BITS + IDX_W;

   localparam int LUT_W  = 16;   // magnitude, 0..32768
   localparam int TRIG_W = 17;   // signed sine / cosine, Q15
   localparam int RAW_W  = 34;   // products and their sums before rounding
   localparam int U_W    = 18;   // phase voltages, signed Q.8
   localparam int SUM_W  = 22;   // centering arithmetic at half-lsb

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int          SQRT3_2_Q15 = 28378;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPLY_VOLTAGE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULATION_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTERED        = 2'd2;

   typedef struct packed {
      logic signed [15:0] volt_q;
      logic signed [15:0] volt_d;
      logic [IN_ANGLE_W-1:0] elec_angle;
   } req_type;

   typedef struct packed {
      logic [15:0] phase_a;
      logic [15:0] phase_b;
      logic [15:0] phase_c;
   } rsp_type;

   typedef struct packed {
      logic [15:0] supply_voltage;
      logic        modulation_mode;
      logic        centered;
   } cfg_type;

   // sine lookup stage to park / clarke stages
   typedef struct packed {
      logic                     valid;
      logic signed [TRIG_W-1:0] sin;
      logic signed [TRIG_W-1:0] cos;
      logic signed [15:0]       volt_q;
      logic signed [15:0]       volt_d;
   } trig_type;

   // clarke stage to centering stages
   typedef struct packed {
      logic                  valid;
      logic signed [U_W-1:0] u_a;
      logic signed [U_W-1:0] u_b;
      logic signed [U_W-1:0] u_c;
   } phase_type;

   typedef logic [LUT_W-1:0] sine_lut_type [0:SINE_TABLE_DEPTH];

   // entry k = sin(pi/2 * k / depth) in Q15, taylor series in Q30
   function automatic sine_lut_type build_sine_lut();
      sine_lut_type       lut;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + $signed(term);
         if (sum < 0) begin
            sum = 0;
         end
         lut[k] = LUT_W'(($unsigned(sum) + 64'd16384) >> 15);
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();

endpackage

[rtl/svpwm_phase_voltage_modulator.sv]
// svpwm_phase_voltage_modulator: top level of the phase voltage modulator,
// register file and five-stage pipeline. Depends on svpm_pkg and the svpm_* stages.
//
// usage
//   command channel: drive req_item (volt_q, volt_d, elec_angle) with start;
//   a beat is taken at a clock edge where start is high and busy is low
//   result channel: rsp_valid strobes for one cycle with the three phase
//   voltages on rsp_item; the receiver cannot stall, so a beat must be
//   caught in that cycle
//   csr channel: csr_valid / csr_ready write; csr_index 0 supply voltage,
//   1 modulation mode, 2 centered; other indexes are ignored
//   result path: a beat passes the sine table, park products, clarke,
//   min / max and centering + saturation registers in turn, and rsp_valid
//   rises as the result register takes the beat
//   throughput: one beat per cycle unless busy; no stalls or back-pressure inside
//   reset: synchronous; empties the pipeline, loads the register defaults
//   (12 V supply, sinusoidal, centered) and holds busy for the cycle after it
//   csr writes are expected only while no beat is in flight
module svpwm_phase_voltage_modulator (
   input  logic                                  clock,
   input  logic                                  reset,
   // command channel
   input  logic                                  start,
   output logic                                  busy,
   input  svpm_pkg::req_type                     req_item,
   // result channel
   output logic                                  rsp_valid,
   output svpm_pkg::rsp_type                     rsp_item,
   // configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [svpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [15:0]                           csr_data
);

   logic                busy_ff;
   logic                accept;
   svpm_pkg::cfg_type   cfg_ff;
   svpm_pkg::trig_type  trig;
   svpm_pkg::phase_type phase;

   // busy for the reset cycle and the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = reset | busy_ff;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   // register file; values are masked to the register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply_voltage  <= 16'd3072;
         cfg_ff.modulation_mode <= 1'b0;
         cfg_ff.centered        <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            svpm_pkg::CSR_SUPPLY_VOLTAGE: begin
               cfg_ff.supply_voltage <= csr_data;
            end
            svpm_pkg::CSR_MODULATION_MODE: begin
               cfg_ff.modulation_mode <= csr_data[0];
            end
            svpm_pkg::CSR_CENTERED: begin
               cfg_ff.centered <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage one: quarter-wave sine / cosine lookup
   svpm_sine_lookup u_sine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_item  (req_item),
      .trig_out (trig)
   );

   // stages two and three: inverse park, clarke
   svpm_park_clarke u_park_clarke (
      .clock     (clock),
      .reset     (reset),
      .trig_in   (trig),
      .phase_out (phase)
   );

   // stages four and five: extremes, centering, saturation
   svpm_center_sat u_center (
      .clock     (clock),
      .reset     (reset),
      .phase_in  (phase),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   // every accepted beat comes out as a result strobe
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted beat did not produce a result strobe");

   // no result strobe without a matching accepted beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result strobe without a matching accepted beat");

endmodule

[rtl/svpm_sine_lookup.sv]
// svpm_sine_lookup: first pipeline stage, sine and cosine from the
// quarter-wave table. Depends on svpm_pkg.
module svpm_sine_lookup (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  svpm_pkg::req_type  in_item,
   output svpm_pkg::trig_type trig_out
);

   logic [svpm_pkg::ANGLE_BITS-1:0] angle;
   logic [1:0]                      quad_sin;
   logic [1:0]                      quad_cos;
   logic [svpm_pkg::FRAC_BITS-1:0]  frac;
   logic [svpm_pkg::PROD_W-1:0]     prod;
   logic [svpm_pkg::IDX_W-1:0]      idx;
   logic [svpm_pkg::IDX_W-1:0]      idx_mirror;
   logic [svpm_pkg::LUT_W-1:0]      mag_sin;
   logic [svpm_pkg::LUT_W-1:0]      mag_cos;
   svpm_pkg::trig_type              trig_in;
   svpm_pkg::trig_type              trig_ff;

   always_comb begin
      angle      = in_item.elec_angle[svpm_pkg::IN_ANGLE_W-1 -: svpm_pkg::ANGLE_BITS];
      quad_sin   = angle[svpm_pkg::ANGLE_BITS-1 -: 2];
      quad_cos   = quad_sin + 2'd1;   // cosine is a quarter turn ahead
      frac       = angle[svpm_pkg::FRAC_BITS-1:0];
      prod       = svpm_pkg::PROD_W'(frac) * svpm_pkg::PROD_W'(svpm_pkg::SINE_TABLE_DEPTH);
      idx        = svpm_pkg::IDX_W'(prod >> svpm_pkg::FRAC_BITS);
      idx_mirror = svpm_pkg::IDX_W'(svpm_pkg::SINE_TABLE_DEPTH) - idx;
      mag_sin    = svpm_pkg::SINE_LUT[quad_sin[0] ? idx_mirror : idx];
      mag_cos    = svpm_pkg::SINE_LUT[quad_cos[0] ? idx_mirror : idx];

      trig_in.valid  = in_valid;
      trig_in.sin    = quad_sin[1] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
      trig_in.cos    = quad_cos[1] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
      trig_in.volt_q = in_item.volt_q;
      trig_in.volt_d = in_item.volt_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '0;
      end else begin
         trig_ff <= trig_in;
      end
   end

   assign trig_out = trig_ff;

endmodule

[rtl/svpm_park_clarke.sv]
// svpm_park_clarke: inverse park products (stage two) and clarke transform
// with rounding (stage three). Depends on svpm_pkg.
module svpm_park_clarke (
   input  logic                clock,
   input  logic                reset,
   input  svpm_pkg::trig_type  trig_in,
   output svpm_pkg::phase_type phase_out
);

   localparam logic signed [svpm_pkg::RAW_W-1:0] ROUND_Q15 = svpm_pkg::RAW_W'(1) <<< 14;
   localparam logic signed [svpm_pkg::RAW_W-1:0] SQRT3_2   =
      svpm_pkg::RAW_W'(svpm_pkg::SQRT3_2_Q15);

   logic                              prod_valid_ff;
   logic signed [svpm_pkg::RAW_W-1:0] alpha_raw_in;
   logic signed [svpm_pkg::RAW_W-1:0] beta_raw_in;
   logic signed [svpm_pkg::RAW_W-1:0] alpha_raw_ff;
   logic signed [svpm_pkg::RAW_W-1:0] beta_raw_ff;

   logic signed [svpm_pkg::RAW_W-1:0] alpha_full;
   logic signed [svpm_pkg::RAW_W-1:0] beta_full;
   logic signed [svpm_pkg::U_W-1:0]   alpha;
   logic signed [svpm_pkg::U_W-1:0]   beta;
   logic signed [svpm_pkg::RAW_W-1:0] half_alpha;
   logic signed [svpm_pkg::RAW_W-1:0] beta_scaled;
   logic signed [svpm_pkg::RAW_W-1:0] ub_raw;
   logic signed [svpm_pkg::RAW_W-1:0] uc_raw;
   svpm_pkg::phase_type               phase_in;
   svpm_pkg::phase_type               phase_ff;

   // inverse park: alpha = c*d - s*q, beta = s*d + c*q
   always_comb begin
      alpha_raw_in = svpm_pkg::RAW_W'(trig_in.cos) * svpm_pkg::RAW_W'(trig_in.volt_d)
                   - svpm_pkg::RAW_W'(trig_in.sin) * svpm_pkg::RAW_W'(trig_in.volt_q);
      beta_raw_in  = svpm_pkg::RAW_W'(trig_in.sin) * svpm_pkg::RAW_W'(trig_in.volt_d)
                   + svpm_pkg::RAW_W'(trig_in.cos) * svpm_pkg::RAW_W'(trig_in.volt_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= trig_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      alpha_raw_ff <= alpha_raw_in;
      beta_raw_ff  <= beta_raw_in;
   end

   // round to Q.8, then clarke with sqrt(3)/2 in Q15
   always_comb begin
      alpha_full  = (alpha_raw_ff + ROUND_Q15) >>> 15;
      beta_full   = (beta_raw_ff + ROUND_Q15) >>> 15;
      alpha       = svpm_pkg::U_W'(alpha_full);
      beta        = svpm_pkg::U_W'(beta_full);
      half_alpha  = svpm_pkg::RAW_W'(alpha) <<< 14;
      beta_scaled = svpm_pkg::RAW_W'(beta) * SQRT3_2;
      ub_raw      = (beta_scaled - half_alpha + ROUND_Q15) >>> 15;
      uc_raw      = (-beta_scaled - half_alpha + ROUND_Q15) >>> 15;

      phase_in.valid = prod_valid_ff;
      phase_in.u_a   = alpha;
      phase_in.u_b   = svpm_pkg::U_W'(ub_raw);
      phase_in.u_c   = svpm_pkg::U_W'(uc_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign phase_out = phase_ff;

endmodule

[rtl/svpm_center_sat.sv]
// svpm_center_sat: phase min / max (stage four), centering or min-shift and
// saturation into the result register (stage five). Depends on svpm_pkg.
module svpm_center_sat (
   input  logic                clock,
   input  logic                reset,
   input  svpm_pkg::phase_type phase_in,
   input  svpm_pkg::cfg_type   cfg,
   output logic                out_valid,
   output svpm_pkg::rsp_type   out_item
);

   localparam logic signed [svpm_pkg::SUM_W-1:0] HALF_UP = svpm_pkg::SUM_W'(1);

   typedef struct packed {
      logic                            valid;
      logic signed [svpm_pkg::U_W-1:0] u_a;
      logic signed [svpm_pkg::U_W-1:0] u_b;
      logic signed [svpm_pkg::U_W-1:0] u_c;
      logic signed [svpm_pkg::U_W-1:0] umin;
      logic signed [svpm_pkg::U_W-1:0] umax;
   } span_type;

   span_type                          span_in;
   span_type                          span_ff;
   logic signed [svpm_pkg::SUM_W-1:0] center2;
   logic                              valid_ff;
   svpm_pkg::rsp_type                 rsp_in;
   svpm_pkg::rsp_type                 rsp_ff;

   function automatic logic [15:0] sat16(input logic signed [svpm_pkg::SUM_W-1:0] v);
      logic [15:0] r;
      if (v[svpm_pkg::SUM_W-1]) begin
         r = 16'h0000;
      end else if (|v[svpm_pkg::SUM_W-2:16]) begin
         r = 16'hFFFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] phase_level(
      input logic signed [svpm_pkg::U_W-1:0]   u,
      input logic signed [svpm_pkg::U_W-1:0]   umin,
      input logic signed [svpm_pkg::SUM_W-1:0] c2,
      input logic                              centered
   );
      logic signed [svpm_pkg::SUM_W-1:0] shifted;
      logic signed [svpm_pkg::SUM_W-1:0] twice;
      logic signed [svpm_pkg::SUM_W-1:0] level;
      shifted = svpm_pkg::SUM_W'(u) - svpm_pkg::SUM_W'(umin);
      twice   = (svpm_pkg::SUM_W'(u) <<< 1) + c2 + HALF_UP;
      level   = twice >>> 1;
      return centered ? sat16(level) : sat16(shifted);
   endfunction

   // stage four: extremes of the three phases
   always_comb begin
      span_in.valid = phase_in.valid;
      span_in.u_a   = phase_in.u_a;
      span_in.u_b   = phase_in.u_b;
      span_in.u_c   = phase_in.u_c;
      span_in.umin  = phase_in.u_a;
      span_in.umax  = phase_in.u_a;
      if (phase_in.u_b < span_in.umin) begin
         span_in.umin = phase_in.u_b;
      end
      if (phase_in.u_b > span_in.umax) begin
         span_in.umax = phase_in.u_b;
      end
      if (phase_in.u_c < span_in.umin) begin
         span_in.umin = phase_in.u_c;
      end
      if (phase_in.u_c > span_in.umax) begin
         span_in.umax = phase_in.u_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= '0;
      end else begin
         span_ff <= span_in;
      end
   end

   // stage five: half-lsb centering, svpwm midpoint, or min-shift; clamp
   always_comb begin
      center2 = $signed(svpm_pkg::SUM_W'(cfg.supply_voltage));
      if (cfg.modulation_mode) begin
         center2 = center2 - (svpm_pkg::SUM_W'(span_ff.umax) + svpm_pkg::SUM_W'(span_ff.umin));
      end
      rsp_in.phase_a = phase_level(span_ff.u_a, span_ff.umin, center2, cfg.centered);
      rsp_in.phase_b = phase_level(span_ff.u_b, span_ff.umin, center2, cfg.centered);
      rsp_in.phase_c = phase_level(span_ff.u_c, span_ff.umin, center2, cfg.centered);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= span_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

endmodule
